// File: sv/tlt_pkg.sv
// Shared types and constants of the tilt target LED indicator.
`timescale 1ns / 1ps

package tlt_pkg;

	localparam int LED_COUNT  = 8;
	localparam int EDGE_COUNT = 9;
	localparam int BIN_W      = 4;

	localparam logic signed [10:0] EDGE_WIDEN = 11'sd20;
	localparam logic signed [10:0] EDGE_RESET [EDGE_COUNT] = '{
		-11'sd500, -11'sd400, -11'sd300, -11'sd200, -11'sd100,
		11'sd200, 11'sd300, 11'sd400, 11'sd500
	};

	localparam logic [2:0] REG_TARGET_X  = 3'd0;
	localparam logic [2:0] REG_TARGET_Y  = 3'd1;
	localparam logic [2:0] REG_ENABLE    = 3'd2;
	localparam logic [2:0] REG_ENTER_THR = 3'd3;
	localparam logic [2:0] REG_EXIT_THR  = 3'd4;

	typedef enum logic [2:0] {
		COL_OFF    = 3'd0,
		COL_BLUE   = 3'd1,
		COL_LBLUE  = 3'd2,
		COL_GREEN  = 3'd3,
		COL_LGREEN = 3'd4,
		COL_RED    = 3'd5,
		COL_LRED   = 3'd6
	} colour_t;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic               enable;
		logic [11:0]        enter_thr;
		logic [11:0]        exit_thr;
	} cfg_t;

	typedef struct packed {
		colour_t [LED_COUNT-1:0] led;
		logic                    on_target;
	} res_t;

endpackage

// File: sv/tlt_cfg_regs.sv
// Configuration register file of the tilt target LED indicator.
`timescale 1ns / 1ps

module tlt_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output tlt_pkg::cfg_t cfg
);

	tlt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x  <= '0;
			cfg_q.target_y  <= '0;
			cfg_q.enable    <= 1'b1;
			cfg_q.enter_thr <= 12'd100;
			cfg_q.exit_thr  <= 12'd120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlt_pkg::REG_TARGET_X:  cfg_q.target_x  <= signed'(cfg_data);
				tlt_pkg::REG_TARGET_Y:  cfg_q.target_y  <= signed'(cfg_data);
				tlt_pkg::REG_ENABLE:    cfg_q.enable    <= cfg_data[0];
				tlt_pkg::REG_ENTER_THR: cfg_q.enter_thr <= cfg_data[11:0];
				tlt_pkg::REG_EXIT_THR:  cfg_q.exit_thr  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/tlt_step.sv
// Hysteresis flags, sticky bin edges and LED pattern logic for one sample.
`timescale 1ns / 1ps

module tlt_step (
	input  logic               clk,
	input  logic               arst_n,
	input  tlt_pkg::cfg_t      cfg,
	input  logic               upd,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	output tlt_pkg::res_t      res
);

	logic                              x_in_q;
	logic                              y_in_q;
	logic [tlt_pkg::EDGE_COUNT-1:0]    widen_q;
	logic [tlt_pkg::EDGE_COUNT-1:0]    widen_d;
	logic signed [16:0]                dx;
	logic signed [16:0]                dy;
	logic [16:0]                       dx_neg;
	logic [16:0]                       dy_neg;
	logic [15:0]                       mag_x;
	logic [15:0]                       mag_y;
	logic                              x_in_d;
	logic                              y_in_d;
	logic [tlt_pkg::EDGE_COUNT-1:0]    le;
	logic signed [10:0]                edge_val [tlt_pkg::EDGE_COUNT];
	logic [tlt_pkg::BIN_W-1:0]         bin;
	logic                              found;
	tlt_pkg::colour_t                  hue_strong;
	tlt_pkg::colour_t                  light;

	assign dx     = 17'(accel_x) - 17'(cfg.target_x);
	assign dy     = 17'(accel_y) - 17'(cfg.target_y);
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign mag_x  = dx[16] ? dx_neg[15:0] : dx[15:0];
	assign mag_y  = dy[16] ? dy_neg[15:0] : dy[15:0];

	// An axis already in range stays in up to the exit threshold inclusive.
	assign x_in_d = x_in_q ? (mag_x <= 16'(cfg.exit_thr)) : (mag_x < 16'(cfg.enter_thr));
	assign y_in_d = y_in_q ? (mag_y <= 16'(cfg.exit_thr)) : (mag_y < 16'(cfg.enter_thr));

	always_comb begin
		for (int i = 0; i < tlt_pkg::EDGE_COUNT; i++) begin
			edge_val[i] = tlt_pkg::EDGE_RESET[i] + (widen_q[i] ? tlt_pkg::EDGE_WIDEN : 11'sd0);
			le[i]       = dx <= 17'(edge_val[i]);
		end
	end

	always_comb begin
		bin   = tlt_pkg::BIN_W'(tlt_pkg::EDGE_COUNT);
		found = 1'b0;
		for (int i = 0; i < tlt_pkg::EDGE_COUNT; i++) begin
			if (!found && le[i]) begin
				bin   = tlt_pkg::BIN_W'(i);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		priority if (y_in_d) begin
			hue_strong = tlt_pkg::COL_BLUE;
			light      = tlt_pkg::COL_LBLUE;
		end else if (dy > 17'sd0) begin
			hue_strong = tlt_pkg::COL_GREEN;
			light      = tlt_pkg::COL_LGREEN;
		end else begin
			hue_strong = tlt_pkg::COL_RED;
			light      = tlt_pkg::COL_LRED;
		end
	end

	always_comb begin
		res.on_target = x_in_d && y_in_d;
		for (int i = 0; i < tlt_pkg::LED_COUNT; i++) begin
			priority if (x_in_d && y_in_d) begin
				res.led[i] = tlt_pkg::COL_BLUE;
			end else if (x_in_d) begin
				res.led[i] = hue_strong;
			end else if (bin == tlt_pkg::BIN_W'(i + 1)) begin
				res.led[i] = hue_strong;
			end else if (bin == tlt_pkg::BIN_W'(i) || bin == tlt_pkg::BIN_W'(i + 2)) begin
				res.led[i] = light;
			end else begin
				res.led[i] = tlt_pkg::COL_OFF;
			end
		end
	end

	// While X is out of range, entering a bin widens its own edge and restores the edge
	// below it, except that the middle bin around zero leaves the edge below untouched.
	always_comb begin
		widen_d = widen_q;
		if (!x_in_d) begin
			for (int i = 0; i < tlt_pkg::EDGE_COUNT; i++) begin
				if (bin == tlt_pkg::BIN_W'(i)) begin
					widen_d[i] = 1'b1;
				end
				if (bin == tlt_pkg::BIN_W'(i + 1) && i != 4) begin
					widen_d[i] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_in_q  <= 1'b0;
			y_in_q  <= 1'b0;
			widen_q <= '0;
		end else if (upd) begin
			x_in_q  <= x_in_d;
			y_in_q  <= y_in_d;
			widen_q <= widen_d;
		end
	end

endmodule

// File: sv/tilt_target_led_indicator.sv
// Top level of the tilt target LED indicator: input and result registers.
`timescale 1ns / 1ps

// Each request carries one X/Y accelerometer sample and, while enabled, yields one
// result with the on-target flag and eight LED color codes. A request can be taken
// every cycle while the output is not stalled; its result is presented on the output
// register after the input register feeds the step logic into the result register.
// While the enable register is clear, samples are accepted and dropped with no result
// and no change of state. The user must write configuration through the plain write
// port only while no sample is in flight; the block itself does not enforce this.
module tilt_target_led_indicator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // accel_x [15:0], accel_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // on_target [0], led0..led7 three bits each from [3:1], zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tlt_pkg::cfg_t      cfg;
	tlt_pkg::res_t      res;
	tlt_pkg::res_t      res_q;
	logic               valid_s1;
	logic signed [15:0] ax_s1;
	logic signed [15:0] ay_s1;
	logic               m_valid_q;
	logic               out_free;
	logic               adv;
	logic               upd;
	logic               take;

	tlt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tlt_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.upd     (upd),
		.accel_x (ax_s1),
		.accel_y (ay_s1),
		.res     (res)
	);

	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && (!cfg.enable || out_free);
	assign upd      = adv && cfg.enable;
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ax_s1 <= signed'(s_tdata[15:0]);
			ay_s1 <= signed'(s_tdata[31:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (upd) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;

	always_comb begin
		m_tdata    = '0;
		m_tdata[0] = res_q.on_target;
		for (int i = 0; i < tlt_pkg::LED_COUNT; i++) begin
			m_tdata[3*i+1 +: 3] = res_q.led[i];
		end
	end

endmodule
